@@ rtl/core/urlpd_pkg.sv @@
// Shared types, constants and helpers for the URL percent decoder.
package urlpd_pkg;

    localparam int MAX_CAPACITY = 4096;
    localparam int CAP_W        = 13;
    localparam int CNT_W        = 13;
    localparam int BYTE_W       = 8;
    localparam int KIND_W       = 2;
    localparam int OUT_TDATA_W  = 24;

    localparam logic [KIND_W-1:0] KIND_DATA = 2'd0;
    localparam logic [KIND_W-1:0] KIND_END  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ERR  = 2'd2;

    localparam logic [BYTE_W-1:0] CH_NUL     = 8'h00;
    localparam logic [BYTE_W-1:0] CH_PERCENT = 8'h25;
    localparam logic [BYTE_W-1:0] CH_PLUS    = 8'h2B;
    localparam logic [BYTE_W-1:0] CH_AMP     = 8'h26;
    localparam logic [BYTE_W-1:0] CH_SPACE   = 8'h20;

    typedef enum logic [3:0] {
        PH_DONE  = 4'b0001,
        PH_PLAIN = 4'b0010,
        PH_HEX1  = 4'b0100,
        PH_HEX2  = 4'b1000
    } t_phase;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              start;
    } t_item;

    typedef struct packed {
        logic              has;
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] data;
        logic [CNT_W-1:0]  length;
    } t_result;

    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } t_nibble;

    // Map an ASCII hex digit to its value; ok is low for any other byte.
    function automatic t_nibble hex_nibble(input logic [BYTE_W-1:0] b);
        t_nibble r;
        r.ok    = 1'b1;
        r.value = 4'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            r.value = 4'(b - 8'h30);
        end else if (b >= 8'h41 && b <= 8'h46) begin
            r.value = 4'(b - 8'h41 + 8'd10);
        end else if (b >= 8'h61 && b <= 8'h66) begin
            r.value = 4'(b - 8'h61 + 8'd10);
        end else begin
            r.ok = 1'b0;
        end
        return r;
    endfunction

endpackage

@@ rtl/core/url_percent_decoder.sv @@
// Top level of the URL percent decoder: input stage, decode step, result register.
//
// Usage:
//   Source bytes of one query parameter value enter on the s-channel, one per
//   transfer: tdata carries the byte, tuser flags the first byte of a new value.
//   Each byte gives zero or one result on the m-channel: tuser carries the kind
//   (data byte, end of value, error), tdata the decoded byte and the running
//   length. '%' (unless the capacity is exceeded) and its first hex digit give
//   no result; bytes after an end or error are dropped until the next start.
//   The cfg channel writes the buffer capacity; it is always ready and must be
//   written only while no item is in flight.
// Timing:
//   A result passes the input register and then the result register before it
//   is presented. One byte is accepted every cycle unless the sink stalls with a
//   result held; the combinational decode step between the two registers sets
//   that rate.
// Reset and stall:
//   Reset empties both registers, sets the capacity to 4096 and leaves the
//   decoder waiting for a start. While the sink stalls with a result held, the
//   input register still takes one byte; bytes that give no result keep moving.
module url_percent_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] in_byte
    input  logic        i_s_tuser,   // [0] start_req
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // [7:0] out_byte, [20:8] length, [23:21] zero
    output logic [1:0]  o_m_tuser,   // [1:0] kind
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [12:0] i_cfg_data   // buffer_capacity
);
    import urlpd_pkg::*;

    t_item            s_item, held_item;
    logic             held_valid;
    logic             advance;
    t_result          step_res, out_res;
    logic             out_valid;
    logic [CAP_W-1:0] r_capacity;

    assign s_item.data  = i_s_tdata;
    assign s_item.start = i_s_tuser;

    // Move the held byte on unless its result would overwrite one still waiting.
    assign advance = held_valid && (!step_res.has || !out_valid || i_m_tready);

    urlpd_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_tvalid),
        .o_ready   (o_s_tready),
        .i_item    (s_item),
        .i_advance (advance),
        .o_valid   (held_valid),
        .o_item    (held_item)
    );

    urlpd_decode u_decode (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_advance  (advance),
        .i_item     (held_item),
        .i_capacity (r_capacity),
        .o_result   (step_res)
    );

    urlpd_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (advance && step_res.has),
        .i_result (step_res),
        .i_ready  (i_m_tready),
        .o_valid  (out_valid),
        .o_result (out_res)
    );

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_W'(4096);
        end else if (i_cfg_valid) begin
            r_capacity <= i_cfg_data;
        end
    end

    assign o_m_tvalid = out_valid;
    assign o_m_tuser  = out_res.kind;
    assign o_m_tdata  = {(OUT_TDATA_W-CNT_W-BYTE_W)'(0), out_res.length, out_res.data};

endmodule

@@ rtl/core/urlpd_in_reg.sv @@
// Input register stage: captures one source byte and its start flag.
module urlpd_in_reg (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  urlpd_pkg::t_item     i_item,
    input  logic                 i_advance,
    output logic                 o_valid,
    output urlpd_pkg::t_item     o_item
);
    import urlpd_pkg::*;

    logic  r_valid;
    t_item r_item;

    // Take a new transfer when empty or when the held item moves on this cycle.
    assign o_ready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

@@ rtl/core/urlpd_decode.sv @@
// Decode step: phase, pending nibble and count registers plus the per-byte logic.
module urlpd_decode (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_advance,
    input  urlpd_pkg::t_item           i_item,
    input  logic [urlpd_pkg::CAP_W-1:0] i_capacity,
    output urlpd_pkg::t_result         o_result
);
    import urlpd_pkg::*;

    t_phase           r_phase, n_phase;
    logic [3:0]       r_high,  n_high;
    logic [CNT_W-1:0] r_count, n_count;

    logic [CAP_W-1:0] cap;
    t_phase           phase_eff;
    logic [CNT_W-1:0] count_eff;
    logic [CNT_W:0]   count_plus3;
    t_nibble          nib;
    t_result          res;

    always_comb begin
        // Clamp the register to the largest supported buffer.
        if (32'(i_capacity) > 32'(MAX_CAPACITY)) begin
            cap = CAP_W'(MAX_CAPACITY);
        end else begin
            cap = i_capacity;
        end
    end

    assign phase_eff   = i_item.start ? PH_PLAIN : r_phase;
    assign count_eff   = i_item.start ? '0 : r_count;
    assign count_plus3 = {1'b0, count_eff} + (CNT_W+1)'(3);
    assign nib         = hex_nibble(i_item.data);

    always_comb begin
        n_phase    = phase_eff;
        n_high     = i_item.start ? 4'd0 : r_high;
        n_count    = count_eff;
        res.has    = 1'b0;
        res.kind   = KIND_DATA;
        res.data   = '0;
        if (i_item.start && cap == '0) begin
            res.has  = 1'b1;
            res.kind = KIND_ERR;
        end else begin
            unique case (phase_eff)
                PH_DONE: begin
                    // drop bytes until the next start
                end
                PH_PLAIN: begin
                    if (i_item.data == CH_NUL || i_item.data == CH_AMP) begin
                        res.has  = 1'b1;
                        res.kind = KIND_END;
                    end else if (count_plus3 >= {1'b0, cap}) begin
                        res.has  = 1'b1;
                        res.kind = KIND_ERR;
                    end else if (i_item.data == CH_PERCENT) begin
                        n_phase = PH_HEX1;
                    end else begin
                        res.has  = 1'b1;
                        res.data = (i_item.data == CH_PLUS) ? CH_SPACE : i_item.data;
                        n_count  = count_eff + CNT_W'(1);
                    end
                end
                PH_HEX1: begin
                    if (nib.ok) begin
                        n_high  = nib.value;
                        n_phase = PH_HEX2;
                    end else begin
                        res.has  = 1'b1;
                        res.kind = KIND_ERR;
                    end
                end
                PH_HEX2: begin
                    if (nib.ok) begin
                        res.has  = 1'b1;
                        res.data = {n_high, nib.value};
                        n_count  = count_eff + CNT_W'(1);
                        n_phase  = PH_PLAIN;
                    end else begin
                        res.has  = 1'b1;
                        res.kind = KIND_ERR;
                    end
                end
                default: begin
                    n_phase = PH_DONE;
                end
            endcase
            // End and error close the value.
            if (res.has && res.kind != KIND_DATA) begin
                n_phase = PH_DONE;
            end
        end
        if (res.has && res.kind != KIND_DATA) begin
            n_phase = PH_DONE;
        end
        res.length = n_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_DONE;
            r_high  <= 4'd0;
            r_count <= '0;
        end else if (i_advance) begin
            r_phase <= n_phase;
            r_high  <= n_high;
            r_count <= n_count;
        end
    end

    assign o_result = res;

endmodule

@@ rtl/core/urlpd_out_reg.sv @@
// Result register: holds one decoded result until the sink takes it.
module urlpd_out_reg (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  urlpd_pkg::t_result   i_result,
    input  logic                 i_ready,
    output logic                 o_valid,
    output urlpd_pkg::t_result   o_result
);
    import urlpd_pkg::*;

    logic    r_valid;
    t_result r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

@@ sim/url_percent_decoder_checker.sv @@
// Checker for the URL percent decoder: predicts each decoded result and compares.
module url_percent_decoder_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] in_byte
    input  logic        i_s_tuser,   // [0] start_req
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [23:0] i_m_tdata,   // [7:0] out_byte, [20:8] length, [23:21] zero
    input  logic [1:0]  i_m_tuser,   // [1:0] kind
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [12:0] i_cfg_data,  // buffer_capacity
    output int          o_failures,
    output int          o_pending
);
    import urlpd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] data;
        logic [CNT_W-1:0]  length;
    } t_decode;

    t_decode              pending_decodes[$];
    t_phase               phase;
    logic [3:0]           hi_digit;
    logic [CNT_W-1:0]     count;
    logic [CAP_W-1:0]     capacity;
    int                   mismatches;

    // Bit 4 flags a valid hex digit, bits 3:0 hold its value.
    function automatic logic [4:0] digit_value(input logic [7:0] c);
        logic [4:0] d;
        d = 5'd0;
        if (c inside {[8'h30:8'h39]}) begin
            d = {1'b1, c[3:0]};
        end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
            d = {1'b1, 4'(c[2:0] + 3'd1) + 4'd8};
        end
        return d;
    endfunction

    task automatic decode_byte(input logic [7:0] b, input logic st);
        int         cap;
        logic [4:0] dig;
        logic       emit_it;
        t_decode    r;
        cap     = (int'(capacity) > MAX_CAPACITY) ? MAX_CAPACITY : int'(capacity);
        dig     = digit_value(b);
        emit_it = 1'b0;
        r.kind  = KIND_DATA;
        r.data  = '0;
        if (st) begin
            phase    = PH_PLAIN;
            hi_digit = 4'd0;
            count    = '0;
            if (cap == 0) begin
                emit_it = 1'b1;
                r.kind  = KIND_ERR;
            end
        end
        if (!emit_it) begin
            case (phase)
                PH_PLAIN: begin
                    // terminators skip the capacity check
                    if (b == CH_NUL || b == CH_AMP) begin
                        emit_it = 1'b1;
                        r.kind  = KIND_END;
                    end else if (int'(count) + 3 >= cap) begin
                        emit_it = 1'b1;
                        r.kind  = KIND_ERR;
                    end else if (b == CH_PERCENT) begin
                        phase = PH_HEX1;
                    end else begin
                        count   = count + 1'b1;
                        emit_it = 1'b1;
                        r.data  = (b == CH_PLUS) ? CH_SPACE : b;
                    end
                end
                PH_HEX1: begin
                    if (!dig[4]) begin
                        emit_it = 1'b1;
                        r.kind  = KIND_ERR;
                    end else begin
                        hi_digit = dig[3:0];
                        phase    = PH_HEX2;
                    end
                end
                PH_HEX2: begin
                    emit_it = 1'b1;
                    if (!dig[4]) begin
                        r.kind = KIND_ERR;
                    end else begin
                        phase  = PH_PLAIN;
                        count  = count + 1'b1;
                        r.data = {hi_digit, dig[3:0]};
                    end
                end
                default: ;
            endcase
        end
        if (emit_it) begin
            r.length = count;
            if (r.kind != KIND_DATA) begin
                phase = PH_DONE;
            end
            pending_decodes.push_back(r);
        end
    endtask

    task automatic check_result();
        t_decode want;
        if (pending_decodes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("%0t: unexpected result kind %0d byte %02h length %0d", $realtime,
                         i_m_tuser, i_m_tdata[7:0], i_m_tdata[20:8]);
            end
        end else begin
            want = pending_decodes.pop_front();
            if (i_m_tuser != want.kind || i_m_tdata[7:0] != want.data ||
                i_m_tdata[20:8] != want.length || i_m_tdata[23:21] != 3'd0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: expected kind %0d byte %02h length %0d pad 0,",
                             $realtime, want.kind, want.data, want.length);
                    $display("    got kind %0d byte %02h length %0d pad %0d",
                             i_m_tuser, i_m_tdata[7:0], i_m_tdata[20:8],
                             i_m_tdata[23:21]);
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            phase      = PH_DONE;
            hi_digit   = 4'd0;
            count      = '0;
            capacity   = CAP_W'(MAX_CAPACITY);
            mismatches = 0;
            pending_decodes.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                capacity = i_cfg_data;
            end
            if (i_s_tvalid && i_s_tready) begin
                decode_byte(i_s_tdata, i_s_tuser);
            end
            if (i_m_tvalid && i_m_tready) begin
                check_result();
            end
        end
        o_pending  <= pending_decodes.size();
        o_failures <= mismatches;
    end

endmodule

@@ sim/testbench.sv @@
// Top of the URL percent decoder simulation: clock, reset, stimulus and verdict.
module testbench;
    import urlpd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 500000;
    localparam int ITEM_GOAL   = 1800;
    localparam int PHASES      = 11;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [12:0] cfg_data;
    int          failures;
    int          pending;
    int          cycles = 0;
    int          items_sent;
    logic        no_idle;

    url_percent_decoder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    url_percent_decoder_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_tvalid),
        .i_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .i_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .i_m_tdata   (m_tdata),
        .i_m_tuser   (m_tuser),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data),
        .o_failures  (failures),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Sink: insert a random stall before each result transfer, none while no_idle is set.
    initial begin
        int stall;
        m_tready <= 1'b0;
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 14);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_tvalid) @(posedge i_clk);
        end
    end

    task automatic send_item(input logic [7:0] b, input logic st, input bit counted = 1'b1);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= st;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        if (counted) begin
            items_sent++;
        end
    endtask

    // Hold off until every expected result has arrived and the pipeline is empty.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [12:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] nib, input bit upper);
        if (nib < 4'd10) begin
            return 8'h30 + 8'(nib);
        end
        return (upper ? 8'h41 : 8'h61) + 8'(nib - 4'd10);
    endfunction

    // One well-formed value: plain bytes, '+' and escapes, then a terminator
    // or nothing, leaving the value open for the next start.
    task automatic send_value();
        int         symbols;
        int         pick;
        logic       st;
        logic [7:0] v;
        if ($urandom_range(0, 9) == 0) begin
            no_idle = !no_idle;
        end
        symbols = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 10);
        st = 1'b1;
        for (int k = 0; k < symbols; k++) begin
            pick = $urandom_range(0, 5);
            if (pick <= 2) begin
                v = 8'($urandom_range(1, 255));
                while (v == CH_AMP || v == CH_PERCENT) v = 8'($urandom_range(1, 255));
                send_item(v, st);
            end else if (pick == 3) begin
                send_item(CH_PLUS, st);
            end else begin
                v = 8'($urandom);
                send_item(CH_PERCENT, st);
                send_item(hex_char(v[7:4], 1'($urandom_range(0, 1))), 1'b0);
                send_item(hex_char(v[3:0], 1'($urandom_range(0, 1))), 1'b0);
            end
            st = 1'b0;
        end
        pick = $urandom_range(0, 9);
        if (pick < 5) begin
            send_item(CH_AMP, st);
        end else if (pick < 9) begin
            send_item(CH_NUL, st);
        end
    endtask

    task automatic send_noise();
        int n;
        case ($urandom_range(0, 3))
            0: begin
                n = $urandom_range(1, 6);
                repeat (n) send_item(8'($urandom), 1'($urandom_range(0, 3) == 0));
            end
            1: begin
                send_item(CH_PERCENT, 1'b1);
                send_item(8'($urandom), 1'b0);
            end
            2: begin
                send_item(CH_PERCENT, 1'b1);
                send_item(hex_char(4'($urandom), 1'($urandom_range(0, 1))), 1'b0);
                send_item(8'($urandom), 1'b0);
            end
            default: begin
                // empty value, then bytes that the idle decoder drops
                send_item(CH_AMP, 1'b1);
                n = $urandom_range(1, 3);
                repeat (n) send_item(8'($urandom), 1'b0, 1'b0);
            end
        endcase
    endtask

    initial begin
        logic [12:0] caps [PHASES];
        int          goal;
        items_sent = 0;
        no_idle    = 1'b0;
        i_rst_n   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= 8'h00;
        s_tuser   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data  <= 13'd0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part at the reset capacity
        send_item(8'h61, 1'b1);
        send_item(CH_PLUS, 1'b0);
        send_item(CH_PERCENT, 1'b0);
        send_item(8'h34, 1'b0);
        send_item(8'h31, 1'b0);
        send_item(CH_PERCENT, 1'b0);
        send_item(8'h66, 1'b0);
        send_item(8'h46, 1'b0);
        send_item(CH_AMP, 1'b0);
        send_item(8'h7E, 1'b0);
        send_item(CH_PERCENT, 1'b1);
        send_item(8'h67, 1'b0);
        send_item(CH_PERCENT, 1'b1);
        send_item(8'h39, 1'b0);
        send_item(CH_NUL, 1'b0);
        send_item(8'hFF, 1'b1);
        send_item(CH_NUL, 1'b1);
        send_item(8'h61, 1'b1);
        send_item(8'h62, 1'b0);
        send_item(8'h63, 1'b0);
        // shrink the capacity under an open value
        write_capacity(13'd5);
        send_item(8'h64, 1'b0);
        write_capacity(13'd0);
        send_item(8'h71, 1'b1);
        write_capacity(13'd4);
        send_item(8'h61, 1'b1);
        send_item(CH_AMP, 1'b0);

        caps = '{13'd0, 13'd3, 13'd4, 13'd5, 13'd8, 13'd20, 13'd8191, 13'd4097,
                 13'd0, 13'd0, 13'd4096};
        caps[8] = 13'($urandom_range(6, 48));
        caps[9] = 13'($urandom_range(6, 48));
        for (int p = 0; p < PHASES; p++) begin
            write_capacity(caps[p]);
            goal = items_sent + ITEM_GOAL / PHASES;
            while (items_sent < goal) begin
                if ($urandom_range(0, 4) == 0) begin
                    send_noise();
                end else begin
                    send_value();
                end
            end
        end

        drain();
        repeat (10) @(posedge i_clk);
        if (failures == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/urlpd_pkg.sv
rtl/core/urlpd_in_reg.sv
rtl/core/urlpd_decode.sv
rtl/core/urlpd_out_reg.sv
rtl/core/url_percent_decoder.sv
sim/url_percent_decoder_checker.sv
sim/testbench.sv
